[rtl/core/acnh_pkg.sv]
// Shared types and constants for the ARP cache next-hop resolver.
package acnh_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_REQUEST = 3'd1,
    ST_STORED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_BUSY    = 3'd4
  } status_t;

  // Register map: index is paddr[3:2]
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
  localparam logic [1:0] REG_GATEWAY_IP  = 2'd1;
  localparam logic [1:0] REG_SUBNET_MASK = 2'd2;

  localparam logic [31:0] SUBNET_MASK_RST = 32'hFFFF_FF00;
  localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
  localparam logic [15:0] ARP_OP_REPLY    = 16'd2;

  // Table entry: IP in the upper bits, MAC in the lower bits
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned ENTRY_W = IP_W + MAC_W;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan;
    logic load_busy;
    logic load_req;
    logic load_hit;
    logic resolve;
    logic push;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic func;
    logic pending;
    logic frame_match;
    logic count_zero;
    logic scan_hit;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/acnh_req_if.sv]
// Input channel: lookup requests and received ARP frame fields.
interface acnh_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] lookup_ip;
  logic [15:0] frame_ethertype;
  logic [15:0] arp_opcode;
  logic [31:0] frame_target_ip;
  logic [47:0] arp_sender_mac;

  modport source (
    output valid, func, lookup_ip, frame_ethertype, arp_opcode, frame_target_ip,
           arp_sender_mac,
    input  ready
  );
  modport sink (
    input  valid, func, lookup_ip, frame_ethertype, arp_opcode, frame_target_ip,
           arp_sender_mac,
    output ready
  );
endinterface

[rtl/core/acnh_rsp_if.sv]
// Output channel: resolver results.
interface acnh_rsp_if;
  logic              valid;
  logic              ready;
  acnh_pkg::status_t status;
  logic [47:0]       mac_address;
  logic [31:0]       request_ip;

  modport source (
    output valid, status, mac_address, request_ip,
    input  ready
  );
  modport sink (
    input  valid, status, mac_address, request_ip,
    output ready
  );
endinterface

[rtl/core/arp_cache_next_hop_resolver_core.sv]
// Top level of the ARP cache next-hop resolver: controller, datapath and register port.
// Each transaction on req is a lookup (func 0) or a received ARP frame (func 1); one
// is worked on at a time. A lookup scans the stored entries through the single read
// port of the entry RAM, one entry per cycle, until a hit or the last entry; an
// ignored frame gives no result. A finished result sits in an output register, so the
// next transaction is taken while it waits on rsp. The table holds TABLE_DEPTH entries
// in write order; a reply that finds it full is returned as table full and not stored.
// Registers lie at 0x0 local_ip, 0x4 gateway_ip and 0x8 subnet_mask; the user must
// write them only while the block is idle, as the block itself does not enforce it.
module arp_cache_next_hop_resolver_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  acnh_req_if.sink                      req,
  acnh_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acnh_pkg::ADDR_W-1:0]   paddr,
  input  logic [acnh_pkg::DATA_W-1:0]   pwdata,
  output logic [acnh_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  acnh_pkg::ctrl_cmd_t cmd;
  acnh_pkg::dp_stat_t  stat;
  logic                cfg_we;

  // APB: zero wait states, write in the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  acnh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acnh_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .func            (req.func),
    .lookup_ip       (req.lookup_ip),
    .frame_ethertype (req.frame_ethertype),
    .arp_opcode      (req.arp_opcode),
    .frame_target_ip (req.frame_target_ip),
    .arp_sender_mac  (req.arp_sender_mac),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_mac         (rsp.mac_address),
    .out_ip          (rsp.request_ip),
    .cfg_we          (cfg_we),
    .cfg_idx         (paddr[3:2]),
    .cfg_wdata       (pwdata),
    .cfg_rdata       (prdata)
  );
endmodule

[rtl/core/acnh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module acnh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/acnh_ctrl.sv]
// Controller FSM: sequences decode, table scan and result hand-off.
module acnh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  acnh_pkg::dp_stat_t   stat,
  output acnh_pkg::ctrl_cmd_t  cmd
);
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (!stat.func && stat.pending) begin
          cmd.load_busy = 1'b1;
          state_next    = S_RESULT;
        end else if (!stat.func && stat.count_zero) begin
          cmd.load_req = 1'b1;
          state_next   = S_RESULT;
        end else if (!stat.func) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (stat.pending && stat.frame_match) begin
          cmd.resolve = 1'b1;
          state_next  = S_RESULT;
        end else begin
          // frame ignored, no result
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.scan_hit) begin
          cmd.load_hit = 1'b1;
          state_next   = S_RESULT;
        end else if (stat.scan_done) begin
          cmd.load_req = 1'b1;
          state_next   = S_RESULT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

[rtl/core/acnh_dp.sv]
// Datapath: config registers, entry table, scan pointer, pending lookup, result and output registers.
module acnh_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // command / status
  input  acnh_pkg::ctrl_cmd_t           cmd,
  output acnh_pkg::dp_stat_t            stat,
  // input payload
  input  logic                          func,
  input  logic [31:0]                   lookup_ip,
  input  logic [15:0]                   frame_ethertype,
  input  logic [15:0]                   arp_opcode,
  input  logic [31:0]                   frame_target_ip,
  input  logic [47:0]                   arp_sender_mac,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output acnh_pkg::status_t             out_status,
  output logic [47:0]                   out_mac,
  output logic [31:0]                   out_ip,
  // register port
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [acnh_pkg::DATA_W-1:0]   cfg_wdata,
  output logic [acnh_pkg::DATA_W-1:0]   cfg_rdata
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  localparam int unsigned IP_W  = acnh_pkg::IP_W;
  localparam int unsigned MAC_W = acnh_pkg::MAC_W;
  localparam int unsigned EW    = acnh_pkg::ENTRY_W;

  // configuration
  logic [31:0] local_ip;
  logic [31:0] gateway_ip;
  logic [31:0] subnet_mask;

  // captured transaction
  logic        func_q;
  logic [31:0] lookup_q;
  logic [15:0] etype_q;
  logic [15:0] opcode_q;
  logic [31:0] tip_q;
  logic [47:0] smac_q;

  // table state
  logic [CW-1:0] entry_count;
  logic          pending_valid;
  logic [31:0]   pending_ip;

  // scan
  logic [CW-1:0] scan_idx;
  logic          rd_valid;
  logic          rd_en;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic          count_full;

  // result held until the output register is free
  acnh_pkg::status_t res_status;
  logic [47:0]       res_mac;
  logic [31:0]       res_ip;

  logic [31:0] req_target;
  logic        same_subnet;

  // Register writes and readback
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip    <= '0;
      gateway_ip  <= '0;
      subnet_mask <= acnh_pkg::SUBNET_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        acnh_pkg::REG_LOCAL_IP:    local_ip    <= cfg_wdata;
        acnh_pkg::REG_GATEWAY_IP:  gateway_ip  <= cfg_wdata;
        acnh_pkg::REG_SUBNET_MASK: subnet_mask <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      acnh_pkg::REG_LOCAL_IP:    cfg_rdata = local_ip;
      acnh_pkg::REG_GATEWAY_IP:  cfg_rdata = gateway_ip;
      acnh_pkg::REG_SUBNET_MASK: cfg_rdata = subnet_mask;
      default:                   cfg_rdata = '0;
    endcase
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q   <= func;
      lookup_q <= lookup_ip;
      etype_q  <= frame_ethertype;
      opcode_q <= arp_opcode;
      tip_q    <= frame_target_ip;
      smac_q   <= arp_sender_mac;
    end
  end

  // Entry table
  assign count_full = (entry_count == FULL_COUNT);
  assign wr_en      = cmd.resolve && !count_full;
  assign rd_en      = cmd.scan && (scan_idx < entry_count);

  acnh_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_count[AW-1:0]),
    .wdata ({pending_ip, smac_q}),
    .re    (rd_en),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rd_data)
  );

  // Scan pointer: one read per cycle, compare in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.scan) begin
      rd_valid <= rd_en;
      if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // Next hop: target itself on the local subnet, gateway otherwise
  assign same_subnet = ((local_ip & subnet_mask) == (lookup_q & subnet_mask));
  assign req_target  = same_subnet ? lookup_q : gateway_ip;

  // Pending lookup and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_ip    <= '0;
      entry_count   <= '0;
    end else begin
      if (cmd.load_req) begin
        pending_valid <= 1'b1;
        pending_ip    <= lookup_q;
      end
      if (cmd.resolve) begin
        pending_valid <= 1'b0;
        if (!count_full) begin
          entry_count <= entry_count + 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    priority if (cmd.load_busy) begin
      res_status <= acnh_pkg::ST_BUSY;
      res_mac    <= '0;
      res_ip     <= '0;
    end else if (cmd.load_req) begin
      res_status <= acnh_pkg::ST_REQUEST;
      res_mac    <= '0;
      res_ip     <= req_target;
    end else if (cmd.load_hit) begin
      res_status <= acnh_pkg::ST_HIT;
      res_mac    <= rd_data[MAC_W-1:0];
      res_ip     <= '0;
    end else if (cmd.resolve) begin
      res_status <= count_full ? acnh_pkg::ST_FULL : acnh_pkg::ST_STORED;
      res_mac    <= smac_q;
      res_ip     <= '0;
    end else begin
      res_status <= res_status;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_status <= res_status;
      out_mac    <= res_mac;
      out_ip     <= res_ip;
    end
  end

  // Status to controller
  assign stat.func        = func_q;
  assign stat.pending     = pending_valid;
  assign stat.frame_match = (etype_q == acnh_pkg::ETHERTYPE_ARP) &&
                            (opcode_q == acnh_pkg::ARP_OP_REPLY) &&
                            (tip_q == local_ip);
  assign stat.count_zero  = (entry_count == '0);
  assign stat.scan_hit    = rd_valid && (rd_data[EW-1:MAC_W] == lookup_q[IP_W-1:0]);
  assign stat.scan_done   = !rd_valid && (scan_idx == entry_count);
  assign stat.out_free    = !out_valid || out_ready;
endmodule

[rtl/core/acnh_checker.sv]
// Port-level checks on the resolver core, bound to the top level.
module acnh_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic [47:0] rsp_mac_address,
  input logic [31:0] rsp_request_ip
);
  // a stalled result transaction holds its payload
  assert property (@(posedge clk) disable iff (rst)
    (!rst && rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_mac_address) &&
       $stable(rsp_request_ip)))
    else $error("result changed while stalled");

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // ARP request and busy results carry no MAC
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == acnh_pkg::ST_REQUEST || rsp_status == acnh_pkg::ST_BUSY))
      |-> (rsp_mac_address == '0))
    else $error("MAC set on request or busy result");

  // only an ARP request carries a request address
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != acnh_pkg::ST_REQUEST) |-> (rsp_request_ip == '0))
    else $error("request address set on non-request result");
endmodule

bind arp_cache_next_hop_resolver_core acnh_checker u_acnh_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_mac_address (rsp.mac_address),
  .rsp_request_ip  (rsp.request_ip)
);

[test/tb_top.sv]
// Self-checking testbench for the ARP cache next-hop resolver core.
module tb_top;

  localparam int CACHE_DEPTH   = 64;
  localparam int RUN_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_RESULTS = 220;
  localparam int NUM_PHASES    = 5;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic        func;
    logic [31:0] lookup_ip;
    logic [15:0] ethertype;
    logic [15:0] opcode;
    logic [31:0] target_ip;
    logic [47:0] sender_mac;
  } arp_req_t;

  typedef struct {
    acnh_pkg::status_t status;
    logic [47:0]       mac;
    logic [31:0]       rip;
  } arp_rsp_t;

  typedef struct {
    arp_req_t item;
    bit       typed;
    bit       has_rsp;
    arp_rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [acnh_pkg::ADDR_W-1:0] paddr;
  logic [acnh_pkg::DATA_W-1:0] pwdata, prdata;

  acnh_req_if req_ch ();
  acnh_rsp_if rsp_ch ();

  arp_cache_next_hop_resolver_core #(.TABLE_DEPTH(CACHE_DEPTH)) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Predictor state: register copies, cache contents and the pending lookup
  logic [31:0] cfg_local, cfg_gateway, cfg_mask;
  logic [31:0] cache_ip [CACHE_DEPTH];
  logic [47:0] cache_mac [CACHE_DEPTH];
  int unsigned cache_fill;
  bit          lookup_pending;
  logic [31:0] pending_addr;

  arp_rsp_t due_results [$];
  int       results_seen = 0;
  int       errors = 0;
  arp_rsp_t oldest;

  // Mirror of one register write
  function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      acnh_pkg::REG_LOCAL_IP:    cfg_local = val;
      acnh_pkg::REG_GATEWAY_IP:  cfg_gateway = val;
      acnh_pkg::REG_SUBNET_MASK: cfg_mask = val;
      default: ;
    endcase
  endfunction

  // Next-hop resolution for one transaction; returns 1 when a result is due
  function automatic bit resolve_next_hop(input arp_req_t it, output arp_rsp_t r);
    r = '{status: acnh_pkg::ST_HIT, mac: '0, rip: '0};
    if (it.func == 1'b0) begin
      if (lookup_pending) begin
        r.status = acnh_pkg::ST_BUSY;
        return 1'b1;
      end
      for (int i = 0; i < cache_fill; i++) begin
        if (cache_ip[i] == it.lookup_ip) begin
          r.status = acnh_pkg::ST_HIT;
          r.mac = cache_mac[i];
          return 1'b1;
        end
      end
      r.status = acnh_pkg::ST_REQUEST;
      r.rip = ((cfg_local & cfg_mask) == (it.lookup_ip & cfg_mask)) ?
              it.lookup_ip : cfg_gateway;
      lookup_pending = 1'b1;
      pending_addr = it.lookup_ip;
      return 1'b1;
    end
    if (!lookup_pending) return 1'b0;
    if (it.ethertype != acnh_pkg::ETHERTYPE_ARP || it.opcode != acnh_pkg::ARP_OP_REPLY ||
        it.target_ip != cfg_local) return 1'b0;
    lookup_pending = 1'b0;
    r.mac = it.sender_mac;
    if (cache_fill < CACHE_DEPTH) begin
      cache_ip[cache_fill] = pending_addr;
      cache_mac[cache_fill] = it.sender_mac;
      cache_fill++;
      r.status = acnh_pkg::ST_STORED;
    end else begin
      r.status = acnh_pkg::ST_FULL;
    end
    return 1'b1;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic dir_row_t mk_row(input logic func, input logic [31:0] ip,
                                      input logic [15:0] etype, input logic [15:0] op,
                                      input logic [31:0] tip, input logic [47:0] mac,
                                      input bit typed, input bit has_rsp,
                                      input acnh_pkg::status_t st, input logic [47:0] emac,
                                      input logic [31:0] erip);
    dir_row_t row;
    row.item = '{func: func, lookup_ip: ip, ethertype: etype, opcode: op,
                 target_ip: tip, sender_mac: mac};
    row.typed = typed;
    row.has_rsp = has_rsp;
    row.rsp = '{status: st, mac: emac, rip: erip};
    return row;
  endfunction

  // Lookup address: stored entry, same subnet, fully random or an extreme
  function automatic logic [31:0] pick_lookup_ip();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    if (r < 38 && cache_fill > 0) return cache_ip[$urandom_range(0, cache_fill - 1)];
    if (r < 70) return (cfg_local & cfg_mask) | ($urandom() & ~cfg_mask);
    return $urandom();
  endfunction

  // Mostly well-formed lookup/reply pairs, with busy lookups and broken frames mixed in
  function automatic arp_req_t make_random_item();
    arp_req_t it;
    int pick;
    it.func       = 1'($urandom_range(0, 1));
    it.lookup_ip  = $urandom();
    it.ethertype  = 16'($urandom_range(0, 16'hFFFF));
    it.opcode     = 16'($urandom_range(0, 16'hFFFF));
    it.target_ip  = $urandom();
    it.sender_mac = rand48();
    pick = $urandom_range(0, 99);
    if (lookup_pending) begin
      if (pick < 82) begin
        it.func = 1'b1;
        it.ethertype = acnh_pkg::ETHERTYPE_ARP;
        it.opcode = acnh_pkg::ARP_OP_REPLY;
        it.target_ip = cfg_local;
        // broken reply: exactly one field off
        if (pick >= 65) begin
          case ($urandom_range(0, 2))
            0: it.ethertype = acnh_pkg::ETHERTYPE_ARP ^
                              (16'($urandom_range(0, 16'hFFFF)) | 16'h1);
            1: it.opcode = acnh_pkg::ARP_OP_REPLY ^
                           (16'($urandom_range(0, 16'hFFFF)) | 16'h8000);
            default: it.target_ip = cfg_local ^ ($urandom() | 32'h1);
          endcase
        end
      end else begin
        it.func = 1'b0;
        it.lookup_ip = pick_lookup_ip();
      end
    end else if (pick < 85) begin
      it.func = 1'b0;
      it.lookup_ip = pick_lookup_ip();
    end else begin
      it.func = 1'b1;
      // a clean reply with nothing pending is dropped as well
      if (pick < 93) begin
        it.ethertype = acnh_pkg::ETHERTYPE_ARP;
        it.opcode = acnh_pkg::ARP_OP_REPLY;
        it.target_ip = cfg_local;
      end
    end
    return it;
  endfunction

  // Offer one transaction, predict on acceptance, then maybe idle
  task automatic issue(input arp_req_t it, input bit typed, input bit typed_has,
                       input arp_rsp_t typed_rsp, output bit produced);
    arp_rsp_t predicted;
    bit has;
    int gap, r;
    req_ch.valid           <= 1'b1;
    req_ch.func            <= it.func;
    req_ch.lookup_ip       <= it.lookup_ip;
    req_ch.frame_ethertype <= it.ethertype;
    req_ch.arp_opcode      <= it.opcode;
    req_ch.frame_target_ip <= it.target_ip;
    req_ch.arp_sender_mac  <= it.sender_mac;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    has = resolve_next_hop(it, predicted);
    if (typed) begin
      has = typed_has;
      predicted = typed_rsp;
    end
    if (has) due_results.push_back(predicted);
    produced = has;
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every due result has arrived
  task automatic drain(input int settle);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Stimulus: directed rows, then random phases under several register settings
  initial begin : stimulus
    dir_row_t dir_rows [$];
    arp_rsp_t none_rsp;
    bit produced;
    int count;
    logic [31:0] loc, gw, mask;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.func <= 1'b0;
    req_ch.lookup_ip <= '0;
    req_ch.frame_ethertype <= '0;
    req_ch.arp_opcode <= '0;
    req_ch.frame_target_ip <= '0;
    req_ch.arp_sender_mac <= '0;

    cfg_local = 32'h0;
    cfg_gateway = 32'h0;
    cfg_mask = acnh_pkg::SUBNET_MASK_RST;
    cache_fill = 0;
    lookup_pending = 1'b0;
    pending_addr = 32'h0;
    none_rsp = '{status: acnh_pkg::ST_HIT, mac: '0, rip: '0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed rows under reset register values (local 0, gateway 0, /24 mask)
    dir_rows.push_back(mk_row(1'b0, 32'h0000_0005, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, acnh_pkg::ST_REQUEST, 48'h0,
                              32'h0000_0005));
    dir_rows.push_back(mk_row(1'b0, 32'h0000_0005, 16'h0, 16'h0, 32'h0, 48'h0,
                              1'b1, 1'b1, acnh_pkg::ST_BUSY, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, 16'h0800, acnh_pkg::ARP_OP_REPLY, 32'h0,
                              48'h1234_5678_9ABC, 1'b1, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, acnh_pkg::ETHERTYPE_ARP, 16'd1, 32'h0,
                              48'h1234_5678_9ABC, 1'b1, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, acnh_pkg::ETHERTYPE_ARP, acnh_pkg::ARP_OP_REPLY,
                              32'h1, 48'h1, 1'b1, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, acnh_pkg::ETHERTYPE_ARP, acnh_pkg::ARP_OP_REPLY,
                              32'h0, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, acnh_pkg::ST_STORED,
                              48'hFFFF_FFFF_FFFF, 32'h0));
    dir_rows.push_back(mk_row(1'b0, 32'h0000_0005, 16'h0, 16'h0, 32'h0, 48'h0,
                              1'b1, 1'b1, acnh_pkg::ST_HIT, 48'hFFFF_FFFF_FFFF, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, acnh_pkg::ETHERTYPE_ARP, acnh_pkg::ARP_OP_REPLY,
                              32'h0, 48'h5, 1'b1, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b0, 32'hFFFF_FFFF, 16'h0, 16'h0, 32'h0, 48'h0,
                              1'b1, 1'b1, acnh_pkg::ST_REQUEST, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'hFFFF_FFFF, acnh_pkg::ETHERTYPE_ARP,
                              acnh_pkg::ARP_OP_REPLY, 32'h0, 48'h0,
                              1'b1, 1'b1, acnh_pkg::ST_STORED, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b0, 32'h0, 16'h0, 16'h0, 32'h0, 48'h0,
                              1'b1, 1'b1, acnh_pkg::ST_REQUEST, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'hFFFF_FFFF, acnh_pkg::ETHERTYPE_ARP,
                              acnh_pkg::ARP_OP_REPLY, 32'h0, 48'h0123_4567_89AB,
                              1'b0, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b0, 32'h0000_00FF, 16'h0, 16'h0, 32'h0, 48'h0,
                              1'b0, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b0, 32'h0000_0100, 16'h0, 16'h0, 32'h0, 48'h0,
                              1'b0, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, acnh_pkg::ETHERTYPE_ARP, 16'd0, 32'h0, 48'h7,
                              1'b0, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, acnh_pkg::ETHERTYPE_ARP, acnh_pkg::ARP_OP_REPLY,
                              32'h0, 48'hFEDC_BA98_7654, 1'b0, 1'b0, acnh_pkg::ST_HIT,
                              48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b0, 32'h0000_0100, 16'h0, 16'h0, 32'h0, 48'h0,
                              1'b0, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b1, 32'h0, acnh_pkg::ETHERTYPE_ARP, acnh_pkg::ARP_OP_REPLY,
                              32'h0, 48'h8000_0000_0000, 1'b0, 1'b0, acnh_pkg::ST_HIT,
                              48'h0, 32'h0));
    dir_rows.push_back(mk_row(1'b0, 32'h0, 16'h0, 16'h0, 32'h0, 48'h0,
                              1'b0, 1'b0, acnh_pkg::ST_HIT, 48'h0, 32'h0));

    foreach (dir_rows[i])
      issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].has_rsp, dir_rows[i].rsp,
            produced);
    drain(SETTLE_CYCLES);

    // Random phases, each under its own register setting
    for (int p = 1; p <= NUM_PHASES; p++) begin
      case (p)
        1: begin loc = $urandom(); gw = $urandom(); mask = acnh_pkg::SUBNET_MASK_RST; end
        2: begin loc = 32'hFFFF_FFFF; gw = 32'hFFFF_FFFF; mask = 32'hFFFF_FFFF; end
        3: begin loc = $urandom(); gw = 32'h0; mask = 32'h0; end
        4: begin loc = $urandom(); gw = $urandom(); mask = ~32'h0 << $urandom_range(0, 32); end
        default: begin loc = 32'h0; gw = 32'hFFFF_FFFF; mask = 32'hFFFF_0000; end
      endcase
      reg_write(acnh_pkg::REG_LOCAL_IP, loc);
      reg_write(acnh_pkg::REG_GATEWAY_IP, gw);
      reg_write(acnh_pkg::REG_SUBNET_MASK, mask);
      // an address past the register list must change nothing
      if (p == 4) reg_write(REG_UNUSED, $urandom());

      count = 0;
      while (count < PHASE_RESULTS) begin
        issue(make_random_item(), 1'b0, 1'b0, none_rsp, produced);
        if (produced) count++;
        // sender pause mid-phase until the output side has caught up
        if (p == 2 && count == 120 && produced) drain(0);
      end
      drain(SETTLE_CYCLES);
    end

    if (errors == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side back-pressure, with one long hold-off while traffic keeps coming
  initial begin : result_sink
    bit held;
    int r;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 40)) @(posedge clk);
      r = $urandom_range(0, 99);
      rsp_ch.ready <= 1'b0;
      if (r < 70) repeat ($urandom_range(1, 2)) @(posedge clk);
      else if (r < 95) repeat ($urandom_range(3, 10)) @(posedge clk);
      else repeat ($urandom_range(20, 100)) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest due one
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: status %0d mac %h ip %h",
                   rsp_ch.status, rsp_ch.mac_address, rsp_ch.request_ip);
        errors++;
      end else begin
        oldest = due_results.pop_front();
        if (rsp_ch.status !== oldest.status || rsp_ch.mac_address !== oldest.mac ||
            rsp_ch.request_ip !== oldest.rip) begin
          if (errors < 10)
            $display("mismatch: status exp %0d got %0d, mac exp %h got %h, ip exp %h got %h",
                     oldest.status, rsp_ch.status, oldest.mac, rsp_ch.mac_address,
                     oldest.rip, rsp_ch.request_ip);
          errors++;
        end
      end
    end
  end

  // Run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
